// ===== src/itp_pkg.sv =====
// Shared types and constants of the integer text parser.
`default_nettype none

package itp_pkg;

   localparam int BASE_W  = 6;
   localparam int CHAR_W  = 8;
   localparam int VALUE_W = 64;
   localparam int END_W   = 12;
   localparam int DIGIT_W = 7;
   localparam int PROD_W  = VALUE_W + BASE_W;

   localparam logic [END_W-1:0] END_MAX = '1;

   // Character codes
   localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
   localparam logic [CHAR_W-1:0] CH_LF      = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_VT      = 8'h0B;
   localparam logic [CHAR_W-1:0] CH_FF      = 8'h0C;
   localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
   localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
   localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UPPER_X = 8'h58;
   localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
   localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LOWER_X = 8'h78;
   localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;

   // Letter to digit value offsets: 'A' - 10 and 'a' - 10
   localparam logic [CHAR_W-1:0] UPPER_OFFSET = 8'd55;
   localparam logic [CHAR_W-1:0] LOWER_OFFSET = 8'd87;

   localparam logic [DIGIT_W-1:0] NO_DIGIT = 7'd64;

   localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
   localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
   localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
   localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;

   localparam logic [PROD_W-1:0] LIMIT_POS = PROD_W'(64'h7FFF_FFFF_FFFF_FFFF);
   localparam logic [PROD_W-1:0] LIMIT_NEG = PROD_W'(64'h8000_0000_0000_0000);

   localparam logic [VALUE_W-1:0] VALUE_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [VALUE_W-1:0] VALUE_MIN = 64'h8000_0000_0000_0000;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_SPACE,
      PH_SIGNED,
      PH_ZERO,
      PH_DIGITS,
      PH_DONE
   } phase_type;

   typedef struct packed {
      logic              start_of_text;
      logic [CHAR_W-1:0] char_code;
   } req_word_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] parsed_value;
      logic [END_W-1:0]          end_index;
      logic                      overflowed;
      logic                      digits_found;
   } rsp_word_type;

   typedef struct packed {
      logic               blank;
      logic               minus;
      logic               plus;
      logic               zero;
      logic               hex_mark;
      logic [DIGIT_W-1:0] digit;
   } char_class_type;

   typedef struct packed {
      logic              live;
      logic              eval;
      logic              set_neg;
      logic              zero_digit;
      logic              is_digit;
      logic [BASE_W-1:0] base;
   } step_ctrl_type;

endpackage

`default_nettype wire

// ===== src/itp_char_decode.sv =====
// Character classifier: blank, sign, prefix marks and digit value.
`default_nettype none

module itp_char_decode (
   input  wire logic [itp_pkg::CHAR_W-1:0] char_code,
   output itp_pkg::char_class_type         char_class
);
   import itp_pkg::*;

   always_comb begin
      char_class.blank    = (char_code == CH_SPACE) || (char_code == CH_TAB) ||
                            (char_code == CH_CR) || (char_code == CH_LF) ||
                            (char_code == CH_FF) || (char_code == CH_VT);
      char_class.minus    = (char_code == CH_MINUS);
      char_class.plus     = (char_code == CH_PLUS);
      char_class.zero     = (char_code == CH_ZERO);
      char_class.hex_mark = (char_code == CH_LOWER_X) || (char_code == CH_UPPER_X);
      priority if (char_code >= CH_ZERO && char_code <= CH_NINE) begin
         char_class.digit = DIGIT_W'(char_code - CH_ZERO);
      end else if (char_code >= CH_UPPER_A && char_code <= CH_UPPER_Z) begin
         char_class.digit = DIGIT_W'(char_code - UPPER_OFFSET);
      end else if (char_code >= CH_LOWER_A && char_code <= CH_LOWER_Z) begin
         char_class.digit = DIGIT_W'(char_code - LOWER_OFFSET);
      end else begin
         char_class.digit = NO_DIGIT;
      end
   end

endmodule

`default_nettype wire

// ===== src/itp_parse_step.sv =====
// Parse state and the per-character step: prefix handling, multiply-add, saturation.
`default_nettype none

module itp_parse_step #(
   parameter int MAX_CHARS = 4096
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       step_en,
   input  wire itp_pkg::req_word_type      word,
   input  wire logic [itp_pkg::BASE_W-1:0] number_base,
   output logic                            emit,
   output itp_pkg::rsp_word_type           result
);
   import itp_pkg::*;

   localparam int PW = $clog2(MAX_CHARS);
   localparam int XW = PW + END_W;
   localparam logic [PW-1:0] POS_LAST = PW'(MAX_CHARS - 1);

   char_class_type     cls;
   step_ctrl_type      ctrl;
   logic               start;

   phase_type          phase_ff, phase_in;
   logic               neg_ff, neg_in;
   logic [VALUE_W-1:0] mag_ff, mag_in;
   logic [BASE_W-1:0]  base_ff;
   logic               seen_ff, seen_in;
   logic               ovf_ff, ovf_in;
   logic [PW-1:0]      pos_ff, pos_in;

   logic [VALUE_W-1:0] mag_cur;
   logic [PROD_W-1:0]  prod;
   logic [PROD_W-1:0]  limit;
   logic [XW-1:0]      pos_ext;

   assign start = word.start_of_text;

   itp_char_decode u_decode (
      .char_code  (word.char_code),
      .char_class (cls)
   );

   // Next phase and step control
   always_comb begin : next_phase
      phase_type ph;
      logic      stop;
      ph         = start ? PH_SPACE : phase_ff;
      stop       = 1'b0;
      ctrl       = '0;
      ctrl.base  = start ? number_base : base_ff;
      ctrl.live  = (ph == PH_SPACE) || (ph == PH_SIGNED) || (ph == PH_ZERO) ||
                   (ph == PH_DIGITS);
      if (!ctrl.live) begin
         stop = 1'b1;
      end
      if (!stop && ph == PH_SPACE) begin
         if (cls.blank) begin
            stop = 1'b1;
         end else begin
            ph = PH_SIGNED;
            if (cls.minus) begin
               ctrl.set_neg = 1'b1;
               stop         = 1'b1;
            end else if (cls.plus) begin
               stop = 1'b1;
            end
         end
      end
      if (!stop) begin
         if (ph == PH_SIGNED) begin
            if ((ctrl.base == BASE_AUTO || ctrl.base == BASE_HEX) && cls.zero) begin
               ph   = PH_ZERO;
               stop = 1'b1;
            end else begin
               if (ctrl.base == BASE_AUTO) begin
                  ctrl.base = BASE_DEC;
               end
               ph = PH_DIGITS;
            end
         end else if (ph == PH_ZERO) begin
            ph = PH_DIGITS;
            if (cls.hex_mark) begin
               ctrl.base = BASE_HEX;
               stop      = 1'b1;
            end else begin
               // the leading zero counts as a digit once no x follows
               ctrl.base       = (ctrl.base == BASE_AUTO) ? BASE_OCT : BASE_HEX;
               ctrl.zero_digit = 1'b1;
            end
         end
      end
      ctrl.is_digit = cls.digit < DIGIT_W'(ctrl.base);
      if (!stop) begin
         ctrl.eval = 1'b1;
         if (!ctrl.is_digit) begin
            ph = PH_DONE;
         end
      end
      phase_in = ph;
   end

   assign mag_cur = start ? '0 : mag_ff;
   assign prod    = PROD_W'(mag_cur) * PROD_W'(ctrl.base) + PROD_W'(cls.digit);

   // Datapath and result
   always_comb begin : step_data
      neg_in  = (start ? 1'b0 : neg_ff) | ctrl.set_neg;
      mag_in  = mag_cur;
      seen_in = (start ? 1'b0 : seen_ff) | ctrl.zero_digit;
      ovf_in  = start ? 1'b0 : ovf_ff;
      priority if (start) begin
         pos_in = '0;
      end else if (ctrl.live && pos_ff != POS_LAST) begin
         pos_in = pos_ff + PW'(1);
      end else begin
         pos_in = pos_ff;
      end
      limit = neg_in ? LIMIT_NEG : LIMIT_POS;
      emit  = 1'b0;
      if (ctrl.eval) begin
         if (ctrl.is_digit) begin
            seen_in = 1'b1;
            if (!ovf_in) begin
               if (prod > limit) begin
                  ovf_in = 1'b1;
               end else begin
                  mag_in = prod[VALUE_W-1:0];
               end
            end
         end else begin
            emit = 1'b1;
         end
      end
      pos_ext = XW'(pos_in);
      result  = '0;
      if (seen_in) begin
         if (ovf_in) begin
            result.parsed_value = neg_in ? VALUE_MIN : VALUE_MAX;
         end else begin
            result.parsed_value = neg_in ? (VALUE_W'(0) - mag_in) : mag_in;
         end
         result.end_index = (pos_ext > XW'(END_MAX)) ? END_MAX : pos_ext[END_W-1:0];
      end
      result.overflowed   = seen_in & ovf_in;
      result.digits_found = seen_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else if (step_en) begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         neg_ff  <= neg_in;
         mag_ff  <= mag_in;
         base_ff <= ctrl.base;
         seen_ff <= seen_in;
         ovf_ff  <= ovf_in;
         pos_ff  <= pos_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/integer_text_parser.sv =====
// A result word is registered from the step when the step takes the character that ends the number.
// Throughput: one character per cycle while no result waits; the step (64x6 multiply-add, limit compare)
//   sits between the input register and the result register.
// A waiting result holds the step; intake stops while the input register holds a word the step cannot take.
// Reset (synchronous, active high) empties both registers, sets the parse idle
//   and clears the base register to 0.
`default_nettype none

module integer_text_parser #(
   parameter int MAX_CHARS = 4096
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire itp_pkg::req_word_type      req_word,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output itp_pkg::rsp_word_type           rsp_word,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [itp_pkg::BASE_W-1:0] csr_number_base
);
   import itp_pkg::*;

   logic              in_valid_ff, in_valid_in;
   req_word_type      in_word_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_word_type      rsp_word_ff;
   logic [BASE_W-1:0] base_ff;
   logic              step_en;
   logic              emit;
   rsp_word_type      result;

   assign csr_ready = 1'b1;

   // advance the input word when the result slot is free or draining
   assign step_en     = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready   = !in_valid_ff || step_en;
   assign in_valid_in = req_ready ? req_valid : in_valid_ff;

   always_comb begin
      priority if (step_en && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   itp_parse_step #(
      .MAX_CHARS (MAX_CHARS)
   ) u_step (
      .clock       (clock),
      .reset       (reset),
      .step_en     (step_en),
      .word        (in_word_ff),
      .number_base (base_ff),
      .emit        (emit),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         base_ff      <= BASE_AUTO;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            base_ff <= csr_number_base;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_word_ff <= req_word;
      end
      if (step_en && emit) begin
         rsp_word_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

`default_nettype wire

// ===== src/itp_checker.sv =====
// Port-level checks of the integer text parser and their bind.
`default_nettype none

module itp_checker (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire itp_pkg::rsp_word_type rsp_word
);
   import itp_pkg::*;

   // hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_no_digit_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.digits_found |->
         rsp_word.parsed_value == 0 && rsp_word.end_index == 0 && !rsp_word.overflowed)
      else $error("result without digits is not all zero");

   a_overflow_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.overflowed |->
         rsp_word.parsed_value == VALUE_MIN || rsp_word.parsed_value == VALUE_MAX)
      else $error("overflowed result is not a limit");

   a_digit_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.digits_found |-> rsp_word.end_index != 0)
      else $error("digits found but end index is zero");

endmodule

bind integer_text_parser itp_checker u_itp_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_word  (rsp_word)
);

`default_nettype wire
